/* src/stall_detect_end_stop_calibration_top_macros.svh */
// Assertion macros shared by the end stop calibration RTL.
`ifndef STALL_DETECT_END_STOP_CALIBRATION_TOP_MACROS_SVH
`define STALL_DETECT_END_STOP_CALIBRATION_TOP_MACROS_SVH

// Same-cycle check: when the antecedent holds, the consequent must hold too.
`define SDES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check: when the antecedent holds, the consequent holds in the cycle after.
`define SDES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sdes_pkg.sv */
// Types, codes and constants for the end stop calibration block.
`default_nettype none
package sdes_pkg;

	localparam int ANGLE_W = 32;
	localparam int STATE_W = (ANGLE_W > 32) ? ANGLE_W : 32;
	localparam int CALC_W  = STATE_W + 2;

	localparam int STALL_W  = 17;
	localparam int RUN_W    = 25;
	localparam int SETTLE_W = 16;

	localparam logic [STALL_W-1:0] DECAY_STEP = STALL_W'(10);

	// Phase codes.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_IDLE_ERR  = 3'd1;
	localparam logic [2:0] PH_CW_START  = 3'd2;
	localparam logic [2:0] PH_CW_RUN    = 3'd3;
	localparam logic [2:0] PH_CCW_START = 3'd4;
	localparam logic [2:0] PH_CCW_RUN   = 3'd5;
	localparam logic [2:0] PH_ERROR     = 3'd6;
	localparam logic [2:0] PH_SUCCESS   = 3'd7;

	// Register indexes.
	localparam logic [2:0] REG_RUN_SPEED     = 3'd0;
	localparam logic [2:0] REG_STALL_TICKS   = 3'd1;
	localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd2;
	localparam logic [2:0] REG_SETTLE_TICKS  = 3'd3;
	localparam logic [2:0] REG_MARGIN        = 3'd4;
	localparam logic [2:0] REG_DEFAULT_MAX   = 3'd5;
	localparam logic [2:0] REG_DEFAULT_MIN   = 3'd6;

	localparam logic signed [31:0] DEFAULT_MAX_RST = 32'sd46080;
	localparam logic signed [31:0] DEFAULT_MIN_RST = -32'sd46080;

	localparam logic signed [CALC_W-1:0] ANG_HI = CALC_W'((64'sd1 <<< (ANGLE_W - 1)) - 64'sd1);
	localparam logic signed [CALC_W-1:0] ANG_LO = ~ANG_HI;

	typedef struct packed {
		logic        [14:0] run_speed;
		logic        [15:0] stall_ticks;
		logic        [23:0] timeout_ticks;
		logic        [15:0] settle_ticks;
		logic        [30:0] margin;
		logic signed [31:0] default_max;
		logic signed [31:0] default_min;
	} cfg_t;

	typedef struct packed {
		logic        [2:0]  phase;
		logic               angle_loop_on;
		logic signed [15:0] speed_command;
		logic signed [31:0] angle_command;
		logic               angle_command_valid;
		logic signed [31:0] lower_limit;
		logic signed [31:0] upper_limit;
		logic               done_pulse;
		logic        [31:0] travel_range;
		logic               calibrated;
		logic               start_rejected;
	} res_t;

	function automatic logic signed [STATE_W-1:0] sat_angle(input logic signed [CALC_W-1:0] v);
		logic signed [CALC_W-1:0] r;
		begin
			if (v > ANG_HI) begin
				r = ANG_HI;
			end else if (v < ANG_LO) begin
				r = ANG_LO;
			end else begin
				r = v;
			end
			return r[STATE_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

/* src/stall_detect_end_stop_calibration_top.sv */
// Top level of the sensorless stall end stop calibration block.
//
//  channel | signals                            | direction
//  --------+------------------------------------+-----------
//  in      | in_valid, in_stall, tick fields    | word in
//  out     | out_valid, out_stall, result fields| word out
//  cfg     | cfg_we, cfg_index, cfg_data        | writes in
//
// Each tick word is taken into an input register and produces one result word
// in the output register on the next edge the output register is free.
// A new word is accepted every cycle in_stall is low; out_valid flags the output word.
// An output stall holds the result word and stalls the input once the input
// register is also full. Reset clears the pipeline and loads the register defaults.
`default_nettype none
`include "stall_detect_end_stop_calibration_top_macros.svh"
module stall_detect_end_stop_calibration_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               start_req,
	input  wire logic signed [15:0] speed_error,
	input  wire logic signed [31:0] now_angle,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [2:0]  phase,
	output logic                    angle_loop_on,
	output logic signed      [15:0] speed_command,
	output logic signed      [31:0] angle_command,
	output logic                    angle_command_valid,
	output logic signed      [31:0] lower_limit,
	output logic signed      [31:0] upper_limit,
	output logic                    done_pulse,
	output logic             [31:0] travel_range,
	output logic                    calibrated,
	output logic                    start_rejected,
	input  wire logic               cfg_we,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [31:0] cfg_data
);
	import sdes_pkg::*;

	cfg_t               cfg;
	res_t               res;
	res_t               res_q;
	logic               valid_s1;
	logic               start_s1;
	logic signed [15:0] err_s1;
	logic signed [31:0] angle_s1;
	logic               out_valid_q;
	logic               out_free;
	logic               fire;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	sdes_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdes_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.start_req   (start_s1),
		.speed_error (err_s1),
		.now_angle   (angle_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= start_req;
			err_s1   <= speed_error;
			angle_s1 <= now_angle;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign phase               = res_q.phase;
	assign angle_loop_on       = res_q.angle_loop_on;
	assign speed_command       = res_q.speed_command;
	assign angle_command       = res_q.angle_command;
	assign angle_command_valid = res_q.angle_command_valid;
	assign lower_limit         = res_q.lower_limit;
	assign upper_limit         = res_q.upper_limit;
	assign done_pulse          = res_q.done_pulse;
	assign travel_range        = res_q.travel_range;
	assign calibrated          = res_q.calibrated;
	assign start_rejected      = res_q.start_rejected;

	`SDES_ASSERT_NOW(a_done_idle, out_valid_q && res_q.done_pulse, (res_q.phase == PH_IDLE) && res_q.calibrated, "done word without idle phase")
	`SDES_ASSERT_NOW(a_cmd_loop, out_valid_q && res_q.angle_command_valid, res_q.angle_loop_on, "angle command with the angle loop off")
	`SDES_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall, "input stalled without a blocked output")
	`SDES_ASSERT_NEXT(a_fire_out, fire, out_valid_q, "processed word did not reach the output register")

endmodule
`default_nettype wire

/* src/sdes_cfg_regs.sv */
// Configuration register file of the end stop calibration block.
`default_nettype none
module sdes_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	output sdes_pkg::cfg_t     cfg
);
	import sdes_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_speed     <= 15'd1000;
			cfg_q.stall_ticks   <= 16'd100;
			cfg_q.timeout_ticks <= 24'd10000;
			cfg_q.settle_ticks  <= 16'd400;
			cfg_q.margin        <= 31'd2560;
			cfg_q.default_max   <= DEFAULT_MAX_RST;
			cfg_q.default_min   <= DEFAULT_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUN_SPEED:     cfg_q.run_speed     <= cfg_data[14:0];
				REG_STALL_TICKS:   cfg_q.stall_ticks   <= cfg_data[15:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data[23:0];
				REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_data[15:0];
				REG_MARGIN:        cfg_q.margin        <= cfg_data[30:0];
				REG_DEFAULT_MAX:   cfg_q.default_max   <= $signed(cfg_data);
				REG_DEFAULT_MIN:   cfg_q.default_min   <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* src/sdes_core.sv */
// Calibration state machine: state registers and next-state and result logic.
`default_nettype none
module sdes_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire logic               start_req,
	input  wire logic signed [15:0] speed_error,
	input  wire logic signed [31:0] now_angle,
	input  wire sdes_pkg::cfg_t     cfg,
	output sdes_pkg::res_t          res
);
	import sdes_pkg::*;

	logic        [2:0]          phase_q, phase_d;
	logic        [STALL_W-1:0]  stall_q, stall_d;
	logic        [RUN_W-1:0]    run_q, run_d;
	logic        [SETTLE_W-1:0] settle_q, settle_d;
	logic signed [STATE_W-1:0]  min_q, min_d;
	logic signed [STATE_W-1:0]  max_q, max_d;
	logic                       loop_q, loop_d;
	logic signed [15:0]         speed_q, speed_d;

	logic signed [16:0]         half_pos, half_neg, err_ext;
	logic signed [CALC_W-1:0]   now_ext, margin_ext;
	logic signed [STATE_W-1:0]  ang_plus, ang_minus;
	logic                       is_idle, cw, stalled;
	logic        [SETTLE_W-1:0] settle_inc;
	logic        [STALL_W-1:0]  stall_inc;
	logic        [RUN_W-1:0]    run_inc;
	logic signed [STATE_W-1:0]  cmd;
	logic                       cmd_valid, done, rejected;
	logic signed [STATE_W-1:0]  range;

	assign half_pos   = $signed({3'b000, cfg.run_speed[14:1]});
	assign half_neg   = -half_pos;
	assign err_ext    = 17'(speed_error);
	assign now_ext    = CALC_W'(now_angle);
	assign margin_ext = $signed({{(CALC_W - 31){1'b0}}, cfg.margin});
	assign ang_plus   = sat_angle(now_ext + margin_ext);
	assign ang_minus  = sat_angle(now_ext - margin_ext);
	assign is_idle    = (phase_q == PH_IDLE) || (phase_q == PH_IDLE_ERR);
	assign cw         = (phase_q == PH_CW_RUN);
	assign stalled    = cw ? (err_ext < half_neg) : (err_ext > half_pos);
	assign settle_inc = (settle_q != '1) ? settle_q + SETTLE_W'(1) : settle_q;
	assign stall_inc  = (stall_q != '1) ? stall_q + STALL_W'(1) : stall_q;
	assign run_inc    = (run_q != '1) ? run_q + RUN_W'(1) : run_q;

	always_comb begin
		phase_d   = phase_q;
		stall_d   = stall_q;
		run_d     = run_q;
		settle_d  = settle_q;
		min_d     = min_q;
		max_d     = max_q;
		loop_d    = loop_q;
		speed_d   = speed_q;
		cmd       = '0;
		cmd_valid = 1'b0;
		done      = 1'b0;
		rejected  = 1'b0;
		range     = '0;
		if (start_req && is_idle) begin
			phase_d  = PH_CW_START;
			settle_d = '0;
		end else begin
			rejected = start_req;
			unique case (phase_q)
				PH_CW_START, PH_CCW_START: begin
					if (settle_q == '0) begin
						stall_d = '0;
						run_d   = '0;
						loop_d  = 1'b0;
						speed_d = (phase_q == PH_CW_START) ?
							-$signed({1'b0, cfg.run_speed}) : $signed({1'b0, cfg.run_speed});
					end
					if (settle_inc >= cfg.settle_ticks) begin
						settle_d = '0;
						phase_d  = (phase_q == PH_CW_START) ? PH_CW_RUN : PH_CCW_RUN;
					end else begin
						settle_d = settle_inc;
					end
				end
				PH_CW_RUN, PH_CCW_RUN: begin
					if (stalled) begin
						stall_d = stall_inc;
						if (stall_inc > {1'b0, cfg.stall_ticks}) begin
							loop_d    = 1'b1;
							cmd_valid = 1'b1;
							if (cw) begin
								min_d    = ang_plus;
								cmd      = ang_plus;
								phase_d  = PH_CCW_START;
								settle_d = '0;
							end else begin
								max_d   = ang_minus;
								cmd     = ang_minus;
								phase_d = PH_SUCCESS;
							end
						end
					end else begin
						stall_d = (stall_q > DECAY_STEP) ? stall_q - DECAY_STEP : '0;
						run_d   = run_inc;
						if (run_inc > {1'b0, cfg.timeout_ticks}) begin
							loop_d    = 1'b1;
							cmd       = cw ? ang_plus : ang_minus;
							cmd_valid = 1'b1;
							phase_d   = PH_ERROR;
						end
					end
				end
				PH_ERROR: begin
					max_d   = STATE_W'(cfg.default_max);
					min_d   = STATE_W'(cfg.default_min);
					phase_d = PH_IDLE_ERR;
				end
				PH_SUCCESS: begin
					if (max_q < min_q) begin
						phase_d = PH_ERROR;
					end else begin
						done    = 1'b1;
						range   = max_q - min_q;
						phase_d = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE_ERR;
			stall_q  <= '0;
			run_q    <= '0;
			settle_q <= '0;
			min_q    <= STATE_W'(DEFAULT_MIN_RST);
			max_q    <= STATE_W'(DEFAULT_MAX_RST);
			loop_q   <= 1'b1;
			speed_q  <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			stall_q  <= stall_d;
			run_q    <= run_d;
			settle_q <= settle_d;
			min_q    <= min_d;
			max_q    <= max_d;
			loop_q   <= loop_d;
			speed_q  <= speed_d;
		end
	end

	// The result word shows the state as it stands after this item.
	always_comb begin
		res.phase               = phase_d;
		res.angle_loop_on       = loop_d;
		res.speed_command       = speed_d;
		res.angle_command       = cmd[31:0];
		res.angle_command_valid = cmd_valid;
		res.lower_limit         = min_d[31:0];
		res.upper_limit         = max_d[31:0];
		res.done_pulse          = done;
		res.travel_range        = range[31:0];
		res.calibrated          = (phase_d == PH_IDLE);
		res.start_rejected      = rejected;
	end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the sensorless end stop calibration block.
`timescale 1ns / 1ps
module tb_top;
	import sdes_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               start_req;
	logic signed [15:0] speed_error;
	logic signed [31:0] now_angle;
	logic               out_valid;
	logic               out_stall;
	logic        [2:0]  phase;
	logic               angle_loop_on;
	logic signed [15:0] speed_command;
	logic signed [31:0] angle_command;
	logic               angle_command_valid;
	logic signed [31:0] lower_limit;
	logic signed [31:0] upper_limit;
	logic               done_pulse;
	logic        [31:0] travel_range;
	logic               calibrated;
	logic               start_rejected;
	logic               cfg_we;
	logic        [2:0]  cfg_index;
	logic        [31:0] cfg_data;

	stall_detect_end_stop_calibration_top dut (.*);

	// Homing predictor state and its copy of the registers.
	logic [2:0]         ph;
	int unsigned        stall_n, run_n, settle_n;
	longint             lo_ang, hi_ang;
	logic               loop_on;
	logic signed [15:0] spd;
	int unsigned        cfg_speed, cfg_stall, cfg_timeout, cfg_settle, cfg_margin;
	longint             cfg_dmax, cfg_dmin;

	res_t status_due[$];
	int   fail_n = 0;
	int   shown_n = 0;
	int   cycle_n = 0;
	int   hold_left = 0;
	bit   calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip_angle(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic int pick_between(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo, 0));
	endfunction

	function automatic string show_status(input res_t r);
		return $sformatf("ph=%0d loop=%0b spd=%0d cmd=%0d/%0b lo=%0d hi=%0d done=%0b range=%0d %s",
			r.phase, r.angle_loop_on, r.speed_command, r.angle_command,
			r.angle_command_valid, r.lower_limit, r.upper_limit, r.done_pulse,
			r.travel_range, $sformatf("cal=%0b rej=%0b", r.calibrated, r.start_rejected));
	endfunction

	// Advances the homing state by one tick and gives the status word it produces.
	task automatic advance_homing(input logic s, input logic signed [15:0] e,
			input logic signed [31:0] a, output res_t r);
		longint err, now, half, rate, back_off, cmd, span;
		bit     cmd_ok, done, busy_start, cw, stalled;
		err = e;
		now = a;
		rate = cfg_speed;
		half = cfg_speed / 2;
		back_off = cfg_margin;
		cmd = 0;
		span = 0;
		cmd_ok = 1'b0;
		done = 1'b0;
		busy_start = 1'b0;
		if (s && (ph == PH_IDLE || ph == PH_IDLE_ERR)) begin
			ph = PH_CW_START;
			settle_n = 0;
		end else begin
			busy_start = s;
			case (ph)
				PH_CW_START, PH_CCW_START: begin
					// The first settling tick starts the move on the speed loop alone.
					if (settle_n == 0) begin
						stall_n = 0;
						run_n = 0;
						loop_on = 1'b0;
						spd = 16'((ph == PH_CW_START) ? -rate : rate);
					end
					if (settle_n < 32'hFFFF)
						settle_n++;
					if (settle_n >= cfg_settle) begin
						settle_n = 0;
						ph = (ph == PH_CW_START) ? PH_CW_RUN : PH_CCW_RUN;
					end
				end
				PH_CW_RUN, PH_CCW_RUN: begin
					cw = (ph == PH_CW_RUN);
					stalled = cw ? (err < -half) : (err > half);
					if (stalled) begin
						if (stall_n < 32'h1FFFF)
							stall_n++;
						if (stall_n > cfg_stall) begin
							loop_on = 1'b1;
							cmd_ok = 1'b1;
							if (cw) begin
								lo_ang = clip_angle(now + back_off);
								cmd = lo_ang;
								ph = PH_CCW_START;
								settle_n = 0;
							end else begin
								hi_ang = clip_angle(now - back_off);
								cmd = hi_ang;
								ph = PH_SUCCESS;
							end
						end
					end else begin
						stall_n = (stall_n > DECAY_STEP) ? stall_n - DECAY_STEP : 0;
						if (run_n < 32'h1FF_FFFF)
							run_n++;
						if (run_n > cfg_timeout) begin
							loop_on = 1'b1;
							cmd = clip_angle(cw ? now + back_off : now - back_off);
							cmd_ok = 1'b1;
							ph = PH_ERROR;
						end
					end
				end
				PH_ERROR: begin
					hi_ang = cfg_dmax;
					lo_ang = cfg_dmin;
					ph = PH_IDLE_ERR;
				end
				PH_SUCCESS: begin
					if (hi_ang < lo_ang) begin
						ph = PH_ERROR;
					end else begin
						done = 1'b1;
						span = hi_ang - lo_ang;
						ph = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
		r.phase = ph;
		r.angle_loop_on = loop_on;
		r.speed_command = spd;
		r.angle_command = 32'(cmd);
		r.angle_command_valid = cmd_ok;
		r.lower_limit = 32'(lo_ang);
		r.upper_limit = 32'(hi_ang);
		r.done_pulse = done;
		r.travel_range = 32'(span);
		r.calibrated = (ph == PH_IDLE);
		r.start_rejected = busy_start;
	endtask

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_tick(input logic s, input logic signed [15:0] e,
			input logic signed [31:0] a);
		res_t want;
		int   gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_req <= s;
		speed_error <= e;
		now_angle <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_homing(s, e, a, want);
		status_due.push_back(want);
		@(negedge clk);
	endtask

	task automatic wait_all_status();
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_RUN_SPEED:     cfg_speed = val[14:0];
			REG_STALL_TICKS:   cfg_stall = val[15:0];
			REG_TIMEOUT_TICKS: cfg_timeout = val[23:0];
			REG_SETTLE_TICKS:  cfg_settle = val[15:0];
			REG_MARGIN:        cfg_margin = val[30:0];
			REG_DEFAULT_MAX:   cfg_dmax = $signed(val);
			REG_DEFAULT_MIN:   cfg_dmin = $signed(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_setup(input int unsigned speed, stall, timeout, settle, margin,
			input int dmax, dmin);
		write_reg(REG_RUN_SPEED, speed);
		write_reg(REG_STALL_TICKS, stall);
		write_reg(REG_TIMEOUT_TICKS, timeout);
		write_reg(REG_SETTLE_TICKS, settle);
		write_reg(REG_MARGIN, margin);
		write_reg(REG_DEFAULT_MAX, dmax);
		write_reg(REG_DEFAULT_MIN, dmin);
	endtask

	// Ticks shaped by the predicted phase so that most runs reach an end stop.
	task automatic send_random_ticks(input int count, input int stall_odds);
		logic               s;
		logic signed [15:0] e;
		logic signed [31:0] a;
		int                 half, pick;
		bit                 idle, run_phase, cw;
		for (int i = 0; i < count; i++) begin
			idle = (ph == PH_IDLE || ph == PH_IDLE_ERR);
			run_phase = (ph == PH_CW_RUN || ph == PH_CCW_RUN);
			cw = (ph == PH_CW_RUN || ph == PH_CW_START);
			s = idle ? ($urandom_range(0, 9) < 6) : ($urandom_range(0, 24) == 0);
			half = cfg_speed / 2;
			pick = $urandom_range(0, 99);
			if (!run_phase || pick < 8)
				e = 16'($urandom);
			else if (pick < 11)
				e = 16'(cw ? -half : half);
			else if (pick < 14)
				e = 16'(cw ? -half - 1 : half + 1);
			else if (pick < stall_odds)
				e = 16'(cw ? pick_between(-32768, -half - 1) : pick_between(half + 1, 32767));
			else
				e = 16'(cw ? pick_between(-half, 32767) : pick_between(-32768, half));
			pick = $urandom_range(0, 19);
			case (pick)
				0: a = 32'sh8000_0000;
				1: a = 32'sh7FFF_FFFF;
				2, 3: a = $urandom;
				default: begin
					a = pick_between(0, 200000);
					// Low end stop on the clockwise move, high one on the way back, with
					// an occasional swap to get inverted ranges.
					if (cw != (pick == 4))
						a = -a;
				end
			endcase
			send_tick(s, e, a);
		end
	endtask

	task automatic test_directed_homing();
		wait_all_status();
		load_setup(200, 1, 1, 1, 100, 46080, -46080);
		// Full calibration with one decayed stall and busy start requests.
		send_tick(1'b0, 0, 0);
		send_tick(1'b1, 0, 0);
		send_tick(1'b1, -5, 0);
		send_tick(1'b0, -32768, -1000);
		send_tick(1'b0, -100, -1000);
		send_tick(1'b0, -101, -1000);
		send_tick(1'b0, -32768, -1000);
		send_tick(1'b0, 0, 0);
		send_tick(1'b0, 101, 5000);
		send_tick(1'b0, 32767, 5000);
		send_tick(1'b1, 0, 0);
		// Saturated end stops that leave an inverted range.
		send_tick(1'b1, 0, 0);
		send_tick(1'b0, 0, 0);
		send_tick(1'b0, -32768, 32'h7FFF_FFFF);
		send_tick(1'b0, -32768, 32'h7FFF_FFFF);
		send_tick(1'b0, 0, 0);
		send_tick(1'b0, 32767, 32'h8000_0000);
		send_tick(1'b0, 32767, 32'h8000_0000);
		send_tick(1'b0, 0, 0);
		send_tick(1'b0, 0, 0);
		// Timeout on the clockwise move.
		send_tick(1'b1, 0, 0);
		send_tick(1'b0, 0, 0);
		send_tick(1'b0, 0, 0);
		send_tick(1'b0, 0, 7);
		send_tick(1'b0, 0, 0);
	endtask

	task automatic test_register_extremes();
		wait_all_status();
		load_setup(32767, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_random_ticks(40, 90);
		wait_all_status();
		load_setup(0, 0, 3, 0, 0, 0, 0);
		send_random_ticks(40, 80);
		wait_all_status();
		load_setup(1, 65535, 32'hFF_FFFF, 2, 1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_random_ticks(30, 90);
	endtask

	task automatic test_long_settle();
		wait_all_status();
		load_setup(500, 0, 10, 50, 10, 46080, -46080);
		calm = 1'b1;
		send_random_ticks(70, 90);
		calm = 1'b0;
	endtask

	task automatic test_random_homing();
		int          sent, chunk, dmax, dmin;
		int unsigned speed, stall, timeout, settle, margin;
		sent = 0;
		while (sent < 1100) begin
			wait_all_status();
			case ($urandom_range(0, 4))
				0: speed = 0;
				1: speed = 32767;
				2: speed = $urandom_range(1, 20);
				3: speed = $urandom_range(0, 32767);
				default: speed = $urandom_range(50, 3000);
			endcase
			stall = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
			timeout = ($urandom_range(0, 5) == 0) ? 32'hFF_FFFF : $urandom_range(0, 80);
			settle = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
			case ($urandom_range(0, 5))
				0: margin = 0;
				1: margin = 32'h7FFF_FFFF;
				2: margin = $urandom_range(32'h7FFF_FFFF, 0);
				default: margin = $urandom_range(0, 5000);
			endcase
			dmax = ($urandom_range(0, 2) == 0) ? $urandom : pick_between(-100000, 100000);
			dmin = ($urandom_range(0, 2) == 0) ? $urandom : pick_between(-100000, 100000);
			load_setup(speed, stall, timeout, settle, margin, dmax, dmin);
			// The last stretch of the run goes without idling on either side.
			if (sent >= 900)
				calm = 1'b1;
			chunk = $urandom_range(40, 140);
			send_random_ticks(chunk, $urandom_range(60, 97));
			sent += chunk;
		end
	endtask

	// Receiver stalls in random bursts.
	always @(negedge clk) begin
		if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0)
			hold_left = $urandom_range(1, 8);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_status
		res_t seen, want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {phase, angle_loop_on, speed_command, angle_command, angle_command_valid,
				lower_limit, upper_limit, done_pulse, travel_range, calibrated, start_rejected};
			if (status_due.size() == 0) begin
				fail_n++;
				if (shown_n < 10) begin
					shown_n++;
					$display("status word with none expected: %s", show_status(seen));
				end
			end else begin
				want = status_due.pop_front();
				if (seen.phase !== want.phase || seen.angle_loop_on !== want.angle_loop_on ||
						seen.speed_command !== want.speed_command ||
						seen.angle_command !== want.angle_command ||
						seen.angle_command_valid !== want.angle_command_valid ||
						seen.lower_limit !== want.lower_limit ||
						seen.upper_limit !== want.upper_limit ||
						seen.done_pulse !== want.done_pulse ||
						seen.travel_range !== want.travel_range ||
						seen.calibrated !== want.calibrated ||
						seen.start_rejected !== want.start_rejected) begin
					fail_n++;
					if (shown_n < 10) begin
						shown_n++;
						$display("status mismatch at %0t", $realtime);
						$display("  expected %s", show_status(want));
						$display("  actual   %s", show_status(seen));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_req = 1'b0;
		speed_error = '0;
		now_angle = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		cfg_speed = 1000;
		cfg_stall = 100;
		cfg_timeout = 10000;
		cfg_settle = 400;
		cfg_margin = 2560;
		cfg_dmax = DEFAULT_MAX_RST;
		cfg_dmin = DEFAULT_MIN_RST;
		ph = PH_IDLE_ERR;
		stall_n = 0;
		run_n = 0;
		settle_n = 0;
		lo_ang = cfg_dmin;
		hi_ang = cfg_dmax;
		loop_on = 1'b1;
		spd = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_homing();
		test_register_extremes();
		test_long_settle();
		test_random_homing();
		wait_all_status();
		repeat (10) @(posedge clk);
		if (fail_n == 0 && status_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
